// File: design/char_lcd_nibble_sequencer_top_macros.svh
// Assertion macros for the character LCD nibble sequencer.
// Used by the top level only; needs a clock aclk and a reset aresetn in scope.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_TOP_MACROS_SVH

// checked only outside reset
`define CLNS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked during reset as well
`define CLNS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: design/clns_pkg.sv
// Shared types and constants for the character LCD nibble sequencer.
// No dependencies.
package clns_pkg;

    typedef enum logic [3:0] {
        OP_INIT   = 4'd0,
        OP_CMD    = 4'd1,
        OP_DATA   = 4'd2,
        OP_CLEAR  = 4'd3,
        OP_GOTO   = 4'd4,
        OP_GOTO_CH = 4'd5,
        OP_SETCUR = 4'd6,
        OP_LEFT   = 4'd7,
        OP_RIGHT  = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        REG_FUNCTION_SET = 2'd0,
        REG_DISPLAY_ON   = 2'd1,
        REG_CLEAR        = 2'd2,
        REG_ENTRY_MODE   = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    localparam int unsigned IDX_W  = 4;   // up to 13 phases per request
    localparam int unsigned WAIT_W = 19;

    localparam logic [7:0] ROW1_BASE   = 8'h7F;
    localparam logic [7:0] ROW2_BASE   = 8'hBF;
    localparam logic [7:0] ROW3_BASE   = 8'h8F;
    localparam logic [7:0] ROW4_BASE   = 8'hCF;
    localparam logic [7:0] LINE0_BASE  = 8'h80;
    localparam logic [7:0] LINE1_BASE  = 8'hC0;
    localparam logic [7:0] SHIFT_LEFT  = 8'h18;
    localparam logic [7:0] SHIFT_RIGHT = 8'h1C;

    localparam logic [WAIT_W-1:0] WAIT_POWER_UP = 19'd15000;
    localparam logic [WAIT_W-1:0] WAIT_WAKE_LONG = 19'd5000;
    localparam logic [WAIT_W-1:0] WAIT_WAKE_SHORT = 19'd100;
    localparam logic [WAIT_W-1:0] WAIT_MODE_4BIT = 19'd40;
    localparam logic [WAIT_W-1:0] WAIT_BYTE     = 19'd1000;
    localparam logic [WAIT_W-1:0] WAIT_CLEAR    = 19'd3000;
    localparam logic [WAIT_W-1:0] WAIT_SETCUR   = 19'd1050;
    localparam logic [WAIT_W-1:0] WAIT_SHIFT    = 19'd501000;

    localparam logic [3:0] NIB_WAKE = 4'h3;
    localparam logic [3:0] NIB_4BIT = 4'h2;

    localparam logic [IDX_W-1:0] INIT_BYTES_START = 4'd5;
    localparam logic [IDX_W-1:0] INIT_LAST_IDX    = 4'd12;

    // one bus phase
    typedef struct packed {
        logic              strobe;
        logic              rs;
        logic [3:0]        nibble;
        logic [WAIT_W-1:0] wait_us;
        logic              bad;
        logic              last;
    } phase_t;

    // controller -> datapath
    typedef struct packed {
        logic             load_req;
        logic             load_out;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic no_phases;   // opcode outside the defined set
        logic last_phase;  // phase at idx closes the request
    } dp_stat_t;

endpackage

// File: design/clns_ctrl.sv
// Controller FSM of the character LCD nibble sequencer.
// Depends on clns_pkg; drives the datapath through dp_cmd_t.
module clns_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  clns_pkg::dp_stat_t  stat,
    output clns_pkg::dp_cmd_t   cmd
);
    import clns_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.load_req = 1'b0;
        cmd.load_out = 1'b0;
        cmd.idx      = idx_reg;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    idx_next     = '0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.no_phases) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    if (stat.last_phase) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// File: design/clns_dp.sv
// Datapath of the character LCD nibble sequencer: request latch, config
// registers, phase decode and output register. Depends on clns_pkg.
module clns_dp (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  clns_pkg::dp_cmd_t        cmd,
    output clns_pkg::dp_stat_t       stat,
    input  logic [3:0]               s_opcode,
    input  logic [7:0]               s_byte_value,
    input  logic [2:0]               s_row,
    input  logic [7:0]               s_column,
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_index,
    input  logic [7:0]               cfg_wr_data,
    output clns_pkg::phase_t         out_phase
);
    import clns_pkg::*;

    logic [7:0] func_set_reg, disp_on_reg, clear_reg, entry_reg;
    op_t        op_reg;
    logic [7:0] bv_reg;
    logic [2:0] row_reg;
    logic [7:0] col_reg;
    phase_t     out_reg;

    phase_t           ph;
    logic [7:0]       row_base, addr, sel_byte;
    logic             row_ok, is_byte, hi, rs;
    logic [WAIT_W-1:0] lo_wait;
    logic [IDX_W-1:0] init_off;
    logic [IDX_W-1:0] idx;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            func_set_reg <= 8'd40;
            disp_on_reg  <= 8'd12;
            clear_reg    <= 8'd1;
            entry_reg    <= 8'd6;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_FUNCTION_SET: func_set_reg <= cfg_wr_data;
                REG_DISPLAY_ON:   disp_on_reg  <= cfg_wr_data;
                REG_CLEAR:        clear_reg    <= cfg_wr_data;
                REG_ENTRY_MODE:   entry_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // request latch and output register (payload only)
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            op_reg  <= op_t'(s_opcode);
            bv_reg  <= s_byte_value;
            row_reg <= s_row;
            col_reg <= s_column;
        end
        if (cmd.load_out) begin
            out_reg <= ph;
        end
    end

    assign idx    = cmd.idx;
    assign row_ok = row_reg inside {[3'd1:3'd4]};

    always_comb begin
        case (row_reg)
            3'd1:    row_base = ROW1_BASE;
            3'd2:    row_base = ROW2_BASE;
            3'd3:    row_base = ROW3_BASE;
            3'd4:    row_base = ROW4_BASE;
            default: row_base = ROW1_BASE;
        endcase
        if (op_reg == OP_SETCUR) begin
            row_base = (row_reg == 3'd0) ? LINE0_BASE : LINE1_BASE;
        end
    end

    assign addr     = row_base + col_reg;
    assign init_off = idx - INIT_BYTES_START;

    always_comb begin
        ph       = '0;
        is_byte  = 1'b0;
        hi       = 1'b0;
        rs       = 1'b0;
        sel_byte = '0;
        lo_wait  = WAIT_BYTE;
        case (op_reg)
            OP_INIT: begin
                ph.last = (idx == INIT_LAST_IDX);
                case (idx)
                    4'd0: ph.wait_us = WAIT_POWER_UP;
                    4'd1: begin
                        ph.strobe  = 1'b1;
                        ph.nibble  = NIB_WAKE;
                        ph.wait_us = WAIT_WAKE_LONG;
                    end
                    4'd2: begin
                        ph.strobe  = 1'b1;
                        ph.nibble  = NIB_WAKE;
                        ph.wait_us = WAIT_WAKE_SHORT;
                    end
                    4'd3: begin
                        ph.strobe  = 1'b1;
                        ph.nibble  = NIB_WAKE;
                        ph.wait_us = WAIT_WAKE_LONG;
                    end
                    4'd4: begin
                        ph.strobe  = 1'b1;
                        ph.nibble  = NIB_4BIT;
                        ph.wait_us = WAIT_MODE_4BIT;
                    end
                    default: begin
                        is_byte = 1'b1;
                        hi      = !init_off[0];
                        case (init_off[2:1])
                            2'd0:    sel_byte = func_set_reg;
                            2'd1:    sel_byte = disp_on_reg;
                            2'd2:    sel_byte = clear_reg;
                            default: sel_byte = entry_reg;
                        endcase
                    end
                endcase
            end
            OP_CMD, OP_DATA: begin
                is_byte  = 1'b1;
                hi       = !idx[0];
                rs       = (op_reg == OP_DATA);
                sel_byte = bv_reg;
                ph.last  = idx[0];
            end
            OP_CLEAR: begin
                is_byte  = 1'b1;
                hi       = !idx[0];
                sel_byte = clear_reg;
                lo_wait  = WAIT_CLEAR;
                ph.last  = idx[0];
            end
            OP_GOTO, OP_GOTO_CH: begin
                if (!row_ok) begin
                    ph.bad  = 1'b1;
                    ph.last = 1'b1;
                end else begin
                    is_byte  = 1'b1;
                    hi       = !idx[0];
                    rs       = idx[1];
                    sel_byte = idx[1] ? bv_reg : addr;
                    ph.last  = (op_reg == OP_GOTO) ? idx[0] : (idx[1] && idx[0]);
                end
            end
            OP_SETCUR: begin
                if (idx == '0) begin
                    ph.wait_us = WAIT_BYTE;
                end else begin
                    is_byte  = 1'b1;
                    hi       = idx[0];
                    sel_byte = addr;
                    lo_wait  = WAIT_SETCUR;
                    ph.last  = idx[1];
                end
            end
            OP_LEFT, OP_RIGHT: begin
                is_byte  = 1'b1;
                hi       = !idx[0];
                sel_byte = (op_reg == OP_LEFT) ? SHIFT_LEFT : SHIFT_RIGHT;
                lo_wait  = WAIT_SHIFT;
                ph.last  = idx[0];
            end
            default: ;
        endcase
        if (is_byte) begin
            ph.strobe  = 1'b1;
            ph.rs      = rs;
            ph.nibble  = hi ? sel_byte[7:4] : sel_byte[3:0];
            ph.wait_us = hi ? '0 : lo_wait;
        end
    end

    assign stat.no_phases  = !(op_reg inside {[OP_INIT:OP_RIGHT]});
    assign stat.last_phase = ph.last;
    assign out_phase       = out_reg;

endmodule

// File: design/char_lcd_nibble_sequencer_top.sv
// Top level of the character LCD nibble sequencer (4-bit HD44780-style bus).
// Depends on clns_pkg, clns_ctrl, clns_dp and the assertion macro header.
//
// One request item expands into a run of bus phase items, one per cycle
// while m_ready is high: init gives 13, command/data/clear/shift give 2,
// goto gives 2, goto plus char 4, set-cursor 3, a goto with a row outside
// 1..4 gives a single phase flagged bad_request, and opcodes 9..15 give
// none. The block takes one request at a time: a request is accepted in
// the idle state, the next cycle starts phase generation and one phase is
// loaded into the output register per cycle while that register is free
// (empty or taken by m_ready); s_ready stays low until the last phase of
// the request is loaded, or until an opcode that emits nothing is dropped.
// The output register lets a new request be taken while the last phase
// of the previous one still waits on m_ready. Config registers are
// written through cfg_wr_en / cfg_index / cfg_wr_data and must only
// change while the block is idle.
module char_lcd_nibble_sequencer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_opcode,
    input  logic [7:0]  s_byte_value,
    input  logic [2:0]  s_row,
    input  logic [7:0]  s_column,
    // phase channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_strobe_res,
    output logic        m_reg_select,
    output logic [3:0]  m_nibble,
    output logic [18:0] m_wait_us,
    output logic        m_bad_request,
    output logic        m_last,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data
);
    import clns_pkg::*;

`include "char_lcd_nibble_sequencer_top_macros.svh"

    dp_cmd_t  cmd;
    dp_stat_t stat;
    phase_t   out_phase;

    // FSM: idle / emitting, phase index, output valid
    clns_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // request latch, config registers, phase decode, output register
    clns_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_opcode     (s_opcode),
        .s_byte_value (s_byte_value),
        .s_row        (s_row),
        .s_column     (s_column),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .out_phase    (out_phase)
    );

    assign m_strobe_res  = out_phase.strobe;
    assign m_reg_select  = out_phase.rs;
    assign m_nibble      = out_phase.nibble;
    assign m_wait_us     = out_phase.wait_us;
    assign m_bad_request = out_phase.bad;
    assign m_last        = out_phase.last;

    // a flagged request closes at once and never strobes
    `CLNS_ASSERT(a_bad_is_final, m_valid && m_bad_request |-> m_last && !m_strobe_res, "bad request phase not final")
    // wait-only phases drive idle bus levels
    `CLNS_ASSERT(a_wait_only_idle, m_valid && !m_strobe_res |-> m_nibble == 4'h0 && !m_reg_select, "wait-only phase with bus data")
    // one request at a time
    `CLNS_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "request accepted while busy")
    // reset empties the output register
    `CLNS_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_valid, "output valid after reset")

endmodule

// File: test/testbench.sv
// Self-checking testbench for the character LCD nibble sequencer.
// Depends on clns_pkg and char_lcd_nibble_sequencer_top. It predicts every bus phase
// from each accepted request and the current init/clear bytes, then checks the phases in order.
module testbench;
    import clns_pkg::*;

    // opcodes outside the defined set; the block drops them without output
    localparam logic [3:0] OP_UNUSED_FIRST = 4'd9;
    localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

    localparam int unsigned HOLD_CYCLES    = 100;  // long m_ready hold-off
    localparam int unsigned WATCHDOG_LIMIT = 2000; // quiet cycles before giving up
    localparam int unsigned SETTLE_CYCLES  = 4;    // covers a no-output request still in flight
    localparam int unsigned END_CYCLES     = 20;
    localparam int unsigned RANDOM_PER_SET = 15;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] char_byte;
        logic [2:0] row;
        logic [7:0] column;
    } lcd_request_t;

    // Expected phase queue plus a copy of the four LCD command bytes.
    class lcd_phase_tracker;
        phase_t      pending[$];
        phase_t      held;        // newest phase, kept back until we know if it closes the request
        bit          held_valid;
        logic [7:0]  cfg_word [4];
        int unsigned fail_count;

        function new();
            cfg_word[REG_FUNCTION_SET] = 8'd40;
            cfg_word[REG_DISPLAY_ON]   = 8'd12;
            cfg_word[REG_CLEAR]        = 8'd1;
            cfg_word[REG_ENTRY_MODE]   = 8'd6;
            held_valid = 1'b0;
            fail_count = 0;
        endfunction

        function void set_register(cfg_reg_t idx, logic [7:0] value);
            cfg_word[idx] = value;
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction

        function void emit_phase(logic strobe, logic rs, logic [3:0] nib,
                                 logic [WAIT_W-1:0] wait_val, logic bad);
            phase_t p;
            if (held_valid)
                pending.push_back(held);
            p.strobe  = strobe;
            p.rs      = rs;
            p.nibble  = nib;
            p.wait_us = wait_val;
            p.bad     = bad;
            p.last    = 1'b0;
            held       = p;
            held_valid = 1'b1;
        endfunction

        // high nibble waits nothing, low nibble carries the request's wait
        function void emit_byte(logic rs, logic [7:0] value, logic [WAIT_W-1:0] wait_val);
            emit_phase(1'b1, rs, value[7:4], '0, 1'b0);
            emit_phase(1'b1, rs, value[3:0], wait_val, 1'b0);
        endfunction

        function void note_request(lcd_request_t req);
            logic [7:0] base;
            logic [7:0] addr;
            bit         row_ok;
            row_ok = 1'b1;
            case (req.row)
                3'd1:    base = ROW1_BASE;
                3'd2:    base = ROW2_BASE;
                3'd3:    base = ROW3_BASE;
                3'd4:    base = ROW4_BASE;
                default: begin
                    base   = '0;
                    row_ok = 1'b0;
                end
            endcase
            case (req.op)
                OP_INIT: begin
                    emit_phase(1'b0, 1'b0, 4'h0, WAIT_POWER_UP, 1'b0);
                    emit_phase(1'b1, 1'b0, NIB_WAKE, WAIT_WAKE_LONG, 1'b0);
                    emit_phase(1'b1, 1'b0, NIB_WAKE, WAIT_WAKE_SHORT, 1'b0);
                    emit_phase(1'b1, 1'b0, NIB_WAKE, WAIT_WAKE_LONG, 1'b0);
                    emit_phase(1'b1, 1'b0, NIB_4BIT, WAIT_MODE_4BIT, 1'b0);
                    emit_byte(1'b0, cfg_word[REG_FUNCTION_SET], WAIT_BYTE);
                    emit_byte(1'b0, cfg_word[REG_DISPLAY_ON], WAIT_BYTE);
                    emit_byte(1'b0, cfg_word[REG_CLEAR], WAIT_BYTE);
                    emit_byte(1'b0, cfg_word[REG_ENTRY_MODE], WAIT_BYTE);
                end
                OP_CMD:   emit_byte(1'b0, req.char_byte, WAIT_BYTE);
                OP_DATA:  emit_byte(1'b1, req.char_byte, WAIT_BYTE);
                OP_CLEAR: emit_byte(1'b0, cfg_word[REG_CLEAR], WAIT_CLEAR);
                OP_GOTO, OP_GOTO_CH: begin
                    if (!row_ok) begin
                        emit_phase(1'b0, 1'b0, 4'h0, '0, 1'b1);
                    end else begin
                        addr = base + req.column;
                        emit_byte(1'b0, addr, WAIT_BYTE);
                        if (req.op == OP_GOTO_CH)
                            emit_byte(1'b1, req.char_byte, WAIT_BYTE);
                    end
                end
                OP_SETCUR: begin
                    addr = ((req.row == 3'd0) ? LINE0_BASE : LINE1_BASE) + req.column;
                    emit_phase(1'b0, 1'b0, 4'h0, WAIT_BYTE, 1'b0);
                    emit_byte(1'b0, addr, WAIT_SETCUR);
                end
                OP_LEFT:  emit_byte(1'b0, SHIFT_LEFT, WAIT_SHIFT);
                OP_RIGHT: emit_byte(1'b0, SHIFT_RIGHT, WAIT_SHIFT);
                default: ;
            endcase
            if (held_valid) begin
                held.last  = 1'b1;
                pending.push_back(held);
                held_valid = 1'b0;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_phase(phase_t got);
            phase_t want;
            if (pending.size() == 0) begin
                $error("phase with nothing pending: nibble %0h wait %0d last %0b",
                       got.nibble, got.wait_us, got.last);
                fail_count++;
                return;
            end
            want = pending.pop_front();
            compare_field("strobe_res", want.strobe, got.strobe);
            compare_field("reg_select", want.rs, got.rs);
            compare_field("nibble", want.nibble, got.nibble);
            compare_field("wait_us", want.wait_us, got.wait_us);
            compare_field("bad_request", want.bad, got.bad);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_opcode;
    logic [7:0]  s_byte_value;
    logic [2:0]  s_row;
    logic [7:0]  s_column;
    logic        m_valid;
    logic        m_ready;
    logic        m_strobe_res;
    logic        m_reg_select;
    logic [3:0]  m_nibble;
    logic [18:0] m_wait_us;
    logic        m_bad_request;
    logic        m_last;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wr_data;

    lcd_phase_tracker tracker;

    // Idling knobs, written by the main sequence only.
    bit          tx_idling;
    bit          rx_idling;
    // Long hold-off handshake: main bumps the request count, receiver serves it.
    int unsigned hold_requests;
    int unsigned hold_served;
    int unsigned quiet_cycles;

    always #1 aclk = ~aclk;

    char_lcd_nibble_sequencer_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_byte_value  (s_byte_value),
        .s_row         (s_row),
        .s_column      (s_column),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_strobe_res  (m_strobe_res),
        .m_reg_select  (m_reg_select),
        .m_nibble      (m_nibble),
        .m_wait_us     (m_wait_us),
        .m_bad_request (m_bad_request),
        .m_last        (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Monitor: both handshakes are sampled at the edge, before any NBA lands.
    // A request taken on the same edge as a phase only appends behind older
    // expectations, so noting it first is safe.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.note_request({s_opcode, s_byte_value, s_row, s_column});
            if (m_valid && m_ready)
                tracker.check_phase({m_strobe_res, m_reg_select, m_nibble,
                                     m_wait_us, m_bad_request, m_last});
        end
    end

    // Watchdog: counts edges on which no item moves and no register is written.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Phase receiver: random stall bursts, plus the long hold-off that lets the
    // output register fill and back up into s_ready.
    initial begin : phase_receiver
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left  = 0;
        hold_left   = 0;
        hold_served = 0;
        m_ready     = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (rx_idling && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one request; return once it is taken and any gap is over. Valid
    // is left high unless a gap follows, so back-to-back items never drop valid.
    task automatic send_request(input lcd_request_t req);
        int unsigned gap;
        s_valid      <= 1'b1;
        s_opcode     <= req.op;
        s_byte_value <= req.char_byte;
        s_row        <= req.row;
        s_column     <= req.column;
        do @(posedge aclk); while (!s_ready);
        if (tx_idling && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Wait until every predicted phase has come out, then let the block settle.
    // Checked on the falling edge so the monitor has already noted this edge.
    task automatic drain_phases(input int unsigned settle);
        s_valid <= 1'b0;
        do @(negedge aclk); while (tracker.outstanding() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    // Write all four command bytes, one per edge; the block must be idle.
    task automatic load_lcd_words(input logic [7:0] fs, input logic [7:0] disp,
                                  input logic [7:0] clr, input logic [7:0] entry);
        logic [7:0] words [4];
        words[0] = fs;
        words[1] = disp;
        words[2] = clr;
        words[3] = entry;
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= cfg_reg_t'(i);
            cfg_wr_data <= words[i];
            tracker.set_register(cfg_reg_t'(i), words[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly defined opcodes; goto rows mostly legal so the address path gets
    // exercised, with some bad rows and unused opcodes mixed in.
    function automatic lcd_request_t random_request();
        lcd_request_t r;
        r.char_byte = 8'($urandom);
        r.column    = 8'($urandom);
        r.row       = 3'($urandom);
        if ($urandom_range(0, 11) == 0)
            r.op = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        else
            r.op = 4'($urandom_range(OP_INIT, OP_RIGHT));
        if ((r.op == OP_GOTO || r.op == OP_GOTO_CH) && $urandom_range(0, 4) != 0)
            r.row = 3'($urandom_range(1, 4));
        return r;
    endfunction

    // Unused opcodes don't count toward the item total.
    task automatic run_random(input int unsigned count);
        int unsigned done_count;
        lcd_request_t req;
        done_count = 0;
        while (done_count < count) begin
            req = random_request();
            send_request(req);
            if (req.op <= OP_RIGHT)
                done_count++;
        end
    endtask

    initial begin
        tracker       = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_opcode      = '0;
        s_byte_value  = '0;
        s_row         = '0;
        s_column      = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wr_data   = '0;
        tx_idling     = 1'b1;
        rx_idling     = 1'b1;
        hold_requests = 0;
        quiet_cycles  = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass on the reset command bytes: every opcode, byte and
        // column extremes, all goto rows legal and bad, both set-cursor lines,
        // address wrap past 0xFF, and opcodes the block drops.
        send_request('{OP_INIT, 8'h00, 3'd0, 8'h00});
        send_request('{OP_CMD, 8'h00, 3'd0, 8'h00});
        send_request('{OP_CMD, 8'hFF, 3'd7, 8'hFF});
        send_request('{OP_DATA, 8'h00, 3'd0, 8'h00});
        send_request('{OP_DATA, 8'hFF, 3'd0, 8'h00});
        send_request('{OP_DATA, 8'hA5, 3'd2, 8'h5A});
        send_request('{OP_CLEAR, 8'h00, 3'd0, 8'h00});
        send_request('{OP_GOTO, 8'h00, 3'd1, 8'h00});
        send_request('{OP_GOTO, 8'h00, 3'd2, 8'hFF});
        send_request('{OP_GOTO, 8'h00, 3'd3, 8'h70});
        send_request('{OP_GOTO, 8'h00, 3'd4, 8'h31});
        send_request('{OP_GOTO, 8'h33, 3'd0, 8'h05});
        send_request('{OP_GOTO, 8'h00, 3'd5, 8'h05});
        send_request('{OP_GOTO_CH, 8'h41, 3'd1, 8'hFF});
        send_request('{OP_GOTO_CH, 8'hFF, 3'd4, 8'h00});
        send_request('{OP_GOTO_CH, 8'h42, 3'd6, 8'h10});
        send_request('{OP_GOTO_CH, 8'h43, 3'd7, 8'hFF});
        send_request('{OP_SETCUR, 8'h00, 3'd0, 8'h00});
        send_request('{OP_SETCUR, 8'h00, 3'd0, 8'hFF});
        send_request('{OP_SETCUR, 8'h00, 3'd7, 8'h10});
        send_request('{OP_SETCUR, 8'h00, 3'd1, 8'h3F});
        send_request('{OP_LEFT, 8'h00, 3'd0, 8'h00});
        send_request('{OP_RIGHT, 8'hFF, 3'd7, 8'hFF});
        send_request('{OP_UNUSED_FIRST, 8'h12, 3'd1, 8'h34});
        send_request('{OP_UNUSED_LAST, 8'hFF, 3'd7, 8'hFF});
        drain_phases(SETTLE_CYCLES);

        // All-zero command bytes. Open with the long hold-off while the sender
        // pushes items back to back, so the block backs up and stalls s_ready.
        load_lcd_words(8'h00, 8'h00, 8'h00, 8'h00);
        hold_requests <= hold_requests + 1;
        tx_idling = 1'b0;
        send_request('{OP_INIT, 8'h00, 3'd0, 8'h00});
        repeat (7) send_request(random_request());
        tx_idling = 1'b1;
        run_random(RANDOM_PER_SET);
        drain_phases(SETTLE_CYCLES);

        // All-ones command bytes
        load_lcd_words(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request('{OP_INIT, 8'h00, 3'd0, 8'h00});
        run_random(RANDOM_PER_SET);
        drain_phases(SETTLE_CYCLES);

        // Random command bytes
        load_lcd_words(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        send_request('{OP_CLEAR, 8'h00, 3'd0, 8'h00});
        run_random(RANDOM_PER_SET);
        drain_phases(SETTLE_CYCLES);

        // Last stretch: fresh bytes, no idling on either side.
        load_lcd_words(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        send_request('{OP_INIT, 8'h00, 3'd0, 8'h00});
        run_random(RANDOM_PER_SET);
        drain_phases(END_CYCLES);

        if (tracker.fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
